// File: rtl/bip_pkg.sv
package bip_pkg;

  localparam int POOL_SIZE = 1024;
  localparam int IDX_W     = $clog2(POOL_SIZE);
  localparam int CNT_W     = $clog2(POOL_SIZE + 1);

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(POOL_SIZE - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(POOL_SIZE);

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_GRANTED  = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_RELEASED = 2'd2,
    STAT_IGNORED  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_LOOK  = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

endpackage

// File: rtl/bip_ram.sv
module bip_ram #(
  parameter int DATA_W = 1,
  parameter int DEPTH  = 2,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: rtl/buffer_index_pool.sv
// Free-list buffer index pool: allocate pops the oldest free index, release pushes it back.
// Path: a request accepted in IDLE goes to LOOK, then to CHECK for an allocate with free entries,
// then to OUT, where the result is registered; a new request is taken only back in IDLE. The pace
// is set by the dependent reads of the single-port free list and busy memories;
// a held result stalls the next one.
// Reset: synchronous active-low; afterwards a clearing pass over all POOL_SIZE (1024) entries
// rebuilds the free list and clears the busy bits before the first request is taken.
module buffer_index_pool (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] index, [15:10] zero
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [9:0] granted_index, [20:10] in_use_count, [31:21] peak_count
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int IW = bip_pkg::IDX_W;
  localparam int CW = bip_pkg::CNT_W;

  bip_pkg::state_t  state_r, state_nxt;
  logic [IW-1:0]    clr_r;
  logic             cmd_r;
  logic [IW-1:0]    idx_r;
  logic [IW-1:0]    id_r;
  logic [IW-1:0]    head_r;
  logic [IW-1:0]    tail_r;
  logic [CW-1:0]    free_r;
  logic [CW-1:0]    total_r;
  logic [CW-1:0]    peak_r;
  bip_pkg::status_t res_status_r;
  logic [IW-1:0]    res_index_r;

  logic             out_valid_r;
  bip_pkg::status_t out_status_r;
  logic [IW-1:0]    out_index_r;
  logic [CW-1:0]    out_count_r;
  logic [CW-1:0]    out_peak_r;

  logic             f_en, f_we;
  logic [IW-1:0]    f_addr, f_wdata, f_rdata;
  logic             b_en, b_we;
  logic [IW-1:0]    b_addr;
  logic [0:0]       b_wdata, b_rdata;

  logic             in_accept;
  logic             out_load;
  logic             rel_ok;
  logic             grant_ok;
  logic [CW-1:0]    total_inc;

  assign in_tready = (state_r == bip_pkg::ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_load  = (state_r == bip_pkg::ST_OUT) && (!out_valid_r || out_tready);
  assign rel_ok    = b_rdata[0] && (free_r < bip_pkg::FULL_CNT);
  assign grant_ok  = !b_rdata[0];
  assign total_inc = total_r + CW'(1);

  bip_ram #(.DATA_W(IW), .DEPTH(bip_pkg::POOL_SIZE)) u_free_ram (
    .clk   (clk),
    .en    (f_en),
    .we    (f_we),
    .addr  (f_addr),
    .wdata (f_wdata),
    .rdata (f_rdata)
  );

  bip_ram #(.DATA_W(1), .DEPTH(bip_pkg::POOL_SIZE)) u_busy_ram (
    .clk   (clk),
    .en    (b_en),
    .we    (b_we),
    .addr  (b_addr),
    .wdata (b_wdata),
    .rdata (b_rdata)
  );

  always_comb begin
    f_en    = 1'b0;
    f_we    = 1'b0;
    f_addr  = head_r;
    f_wdata = idx_r;
    b_en    = 1'b0;
    b_we    = 1'b0;
    b_addr  = idx_r;
    b_wdata = 1'b0;
    case (state_r)
      bip_pkg::ST_CLEAR: begin
        f_en    = 1'b1;
        f_we    = 1'b1;
        f_addr  = clr_r;
        f_wdata = clr_r;
        b_en    = 1'b1;
        b_we    = 1'b1;
        b_addr  = clr_r;
      end
      bip_pkg::ST_IDLE: begin
        f_en   = in_accept;
        b_en   = in_accept;
        b_addr = in_tdata[IW-1:0];
      end
      bip_pkg::ST_LOOK: begin
        if (cmd_r == bip_pkg::CMD_ALLOC) begin
          b_en   = (free_r != '0);
          b_addr = f_rdata;
        end else if (rel_ok) begin
          f_en   = 1'b1;
          f_we   = 1'b1;
          f_addr = tail_r;
          b_en   = 1'b1;
          b_we   = 1'b1;
        end
      end
      bip_pkg::ST_CHECK: begin
        b_en    = grant_ok;
        b_we    = grant_ok;
        b_addr  = id_r;
        b_wdata = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bip_pkg::ST_CLEAR: if (clr_r == bip_pkg::LAST_IDX) state_nxt = bip_pkg::ST_IDLE;
      bip_pkg::ST_IDLE:  if (in_accept) state_nxt = bip_pkg::ST_LOOK;
      bip_pkg::ST_LOOK: begin
        if (cmd_r == bip_pkg::CMD_ALLOC && free_r != '0) begin
          state_nxt = bip_pkg::ST_CHECK;
        end else begin
          state_nxt = bip_pkg::ST_OUT;
        end
      end
      bip_pkg::ST_CHECK: state_nxt = bip_pkg::ST_OUT;
      bip_pkg::ST_OUT:   if (out_load) state_nxt = bip_pkg::ST_IDLE;
      default:           state_nxt = bip_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bip_pkg::ST_CLEAR;
      clr_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      free_r      <= bip_pkg::FULL_CNT;
      total_r     <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == bip_pkg::ST_CLEAR) begin
        clr_r <= clr_r + IW'(1);
      end
      case (state_r)
        bip_pkg::ST_LOOK: begin
          if (cmd_r == bip_pkg::CMD_RELEASE && rel_ok) begin
            tail_r  <= (tail_r == bip_pkg::LAST_IDX) ? '0 : tail_r + IW'(1);
            free_r  <= free_r + CW'(1);
            if (total_r != '0) begin
              total_r <= total_r - CW'(1);
            end
          end
        end
        bip_pkg::ST_CHECK: begin
          if (grant_ok) begin
            head_r  <= (head_r == bip_pkg::LAST_IDX) ? '0 : head_r + IW'(1);
            free_r  <= free_r - CW'(1);
            total_r <= total_inc;
            if (total_inc > peak_r) begin
              peak_r <= total_inc;
            end
          end
        end
        default: begin
        end
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r <= in_tuser;
      idx_r <= in_tdata[IW-1:0];
    end
    case (state_r)
      bip_pkg::ST_LOOK: begin
        id_r        <= f_rdata;
        res_index_r <= '0;
        if (cmd_r == bip_pkg::CMD_ALLOC) begin
          res_status_r <= bip_pkg::STAT_EMPTY;
        end else if (rel_ok) begin
          res_status_r <= bip_pkg::STAT_RELEASED;
        end else begin
          res_status_r <= bip_pkg::STAT_IGNORED;
        end
      end
      bip_pkg::ST_CHECK: begin
        if (grant_ok) begin
          res_status_r <= bip_pkg::STAT_GRANTED;
          res_index_r  <= id_r;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_status_r <= res_status_r;
      out_index_r  <= res_index_r;
      out_count_r  <= total_r;
      out_peak_r   <= peak_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_peak_r, out_count_r, out_index_r};

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
module testbench;

  typedef struct packed {
    bip_pkg::status_t          status;
    logic [bip_pkg::IDX_W-1:0] granted;
    logic [bip_pkg::CNT_W-1:0] in_use;
    logic [bip_pkg::CNT_W-1:0] peak;
  } pool_reply_t;

  typedef struct packed {
    bip_pkg::cmd_t             cmd;
    logic [bip_pkg::IDX_W-1:0] idx;
    logic                      typed;
    pool_reply_t               reply;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'd0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  logic [bip_pkg::IDX_W-1:0] free_list [bip_pkg::POOL_SIZE];
  logic                      busy_map [bip_pkg::POOL_SIZE];
  logic [bip_pkg::IDX_W-1:0] pop_ptr;
  logic [bip_pkg::IDX_W-1:0] push_ptr;
  logic [bip_pkg::CNT_W-1:0] free_cnt;
  logic [bip_pkg::CNT_W-1:0] busy_cnt;
  logic [bip_pkg::CNT_W-1:0] busy_max;

  pool_reply_t               pending_replies [$];
  pool_reply_t               reply_want;
  logic [bip_pkg::IDX_W-1:0] held_indices [$];
  int                        mismatches = 0;
  int                        empty_replies = 0;
  int                        burst_left = 0;
  bit                        hold_off_pending = 1'b0;

  directed_row_t directed_rows [0:15] = '{
    '{bip_pkg::CMD_ALLOC,   10'd0,    1'b1, '{bip_pkg::STAT_GRANTED,  10'd0, 11'd1, 11'd1}},
    '{bip_pkg::CMD_ALLOC,   10'd1023, 1'b1, '{bip_pkg::STAT_GRANTED,  10'd1, 11'd2, 11'd2}},
    '{bip_pkg::CMD_RELEASE, 10'd0,    1'b1, '{bip_pkg::STAT_RELEASED, 10'd0, 11'd1, 11'd2}},
    '{bip_pkg::CMD_RELEASE, 10'd0,    1'b1, '{bip_pkg::STAT_IGNORED,  10'd0, 11'd1, 11'd2}},
    '{bip_pkg::CMD_RELEASE, 10'd1023, 1'b1, '{bip_pkg::STAT_IGNORED,  10'd0, 11'd1, 11'd2}},
    '{bip_pkg::CMD_RELEASE, 10'd1,    1'b1, '{bip_pkg::STAT_RELEASED, 10'd0, 11'd0, 11'd2}},
    '{bip_pkg::CMD_RELEASE, 10'd1,    1'b1, '{bip_pkg::STAT_IGNORED,  10'd0, 11'd0, 11'd2}},
    '{bip_pkg::CMD_ALLOC,   10'd0,    1'b1, '{bip_pkg::STAT_GRANTED,  10'd2, 11'd1, 11'd2}},
    '{bip_pkg::CMD_ALLOC,   10'd0,    1'b1, '{bip_pkg::STAT_GRANTED,  10'd3, 11'd2, 11'd2}},
    '{bip_pkg::CMD_ALLOC,   10'd0,    1'b1, '{bip_pkg::STAT_GRANTED,  10'd4, 11'd3, 11'd3}},
    '{bip_pkg::CMD_RELEASE, 10'd3,    1'b0, '0},
    '{bip_pkg::CMD_ALLOC,   10'd0,    1'b0, '0},
    '{bip_pkg::CMD_RELEASE, 10'd4,    1'b0, '0},
    '{bip_pkg::CMD_RELEASE, 10'd512,  1'b0, '0},
    '{bip_pkg::CMD_ALLOC,   10'd0,    1'b0, '0},
    '{bip_pkg::CMD_RELEASE, 10'd2,    1'b0, '0}
  };

  buffer_index_pool DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [bip_pkg::IDX_W-1:0] ptr_next(
      input logic [bip_pkg::IDX_W-1:0] p);
    return (p == bip_pkg::LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  function automatic pool_reply_t predict_pool_reply(
      input bip_pkg::cmd_t cmd, input logic [bip_pkg::IDX_W-1:0] idx);
    pool_reply_t               r;
    logic [bip_pkg::IDX_W-1:0] id;
    r.granted = '0;
    if (cmd == bip_pkg::CMD_ALLOC) begin
      id = free_list[pop_ptr];
      if (free_cnt == 0 || busy_map[id]) begin
        r.status = bip_pkg::STAT_EMPTY;
      end else begin
        pop_ptr = ptr_next(pop_ptr);
        free_cnt = free_cnt - 1'b1;
        busy_map[id] = 1'b1;
        busy_cnt = busy_cnt + 1'b1;
        if (busy_cnt > busy_max) busy_max = busy_cnt;
        r.status = bip_pkg::STAT_GRANTED;
        r.granted = id;
      end
    end else if (!busy_map[idx] || free_cnt >= bip_pkg::FULL_CNT) begin
      r.status = bip_pkg::STAT_IGNORED;
    end else begin
      free_list[push_ptr] = idx;
      push_ptr = ptr_next(push_ptr);
      free_cnt = free_cnt + 1'b1;
      busy_map[idx] = 1'b0;
      if (busy_cnt > 0) busy_cnt = busy_cnt - 1'b1;
      r.status = bip_pkg::STAT_RELEASED;
    end
    r.in_use = busy_cnt;
    r.peak = busy_max;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected reply", int'(out_tuser), -1);
      end else begin
        reply_want = pending_replies.pop_front();
        if (out_tuser != reply_want.status)
          report_mismatch("status", int'(out_tuser), int'(reply_want.status));
        if (out_tdata[9:0] != reply_want.granted)
          report_mismatch("granted_index", int'(out_tdata[9:0]), int'(reply_want.granted));
        if (out_tdata[20:10] != reply_want.in_use)
          report_mismatch("in_use_count", int'(out_tdata[20:10]), int'(reply_want.in_use));
        if (out_tdata[31:21] != reply_want.peak)
          report_mismatch("peak_count", int'(out_tdata[31:21]), int'(reply_want.peak));
      end
    end
  end

  task automatic send_request(input bip_pkg::cmd_t cmd,
                              input logic [bip_pkg::IDX_W-1:0] idx,
                              input bit typed, input pool_reply_t typed_reply);
    pool_reply_t r;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'd0, idx};
    do @(posedge clk); while (!in_tready);
    r = predict_pool_reply(cmd, idx);
    pending_replies.push_back(typed ? typed_reply : r);
    if (r.status == bip_pkg::STAT_GRANTED) held_indices.push_back(r.granted);
    if (r.status == bip_pkg::STAT_EMPTY) empty_replies++;
    if (r.status == bip_pkg::STAT_RELEASED) begin
      for (int i = 0; i < held_indices.size(); i++) begin
        if (held_indices[i] == idx) begin
          held_indices.delete(i);
          break;
        end
      end
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 16);
    end
  endtask

  task automatic send_random_request(input int alloc_pct);
    logic [bip_pkg::IDX_W-1:0] idx;
    idx = bip_pkg::IDX_W'($urandom_range(0, bip_pkg::POOL_SIZE - 1));
    if ($urandom_range(0, 99) < alloc_pct || held_indices.size() == 0) begin
      send_request(bip_pkg::CMD_ALLOC, idx, 1'b0, '0);
    end else begin
      if ($urandom_range(0, 99) < 85)
        idx = held_indices[$urandom_range(0, held_indices.size() - 1)];
      send_request(bip_pkg::CMD_RELEASE, idx, 1'b0, '0);
    end
  endtask

  task automatic wait_all_replies();
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  initial begin : receiver
    int mode;
    int span;
    wait (rst_n);
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_tready <= 1'b0;
        repeat (200) @(posedge clk);
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(8, 64);
      repeat (span) begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int n;
    for (int i = 0; i < bip_pkg::POOL_SIZE; i++) begin
      free_list[i] = bip_pkg::IDX_W'(i);
      busy_map[i] = 1'b0;
    end
    pop_ptr = '0;
    push_ptr = '0;
    free_cnt = bip_pkg::FULL_CNT;
    busy_cnt = '0;
    busy_max = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].cmd, directed_rows[i].idx,
                   directed_rows[i].typed, directed_rows[i].reply);
    wait_all_replies();

    n = 0;
    while (empty_replies < 4 && n < 1400) begin
      send_random_request(95);
      n++;
    end
    wait_all_replies();

    hold_off_pending = 1'b1;
    repeat (250) send_random_request(30);
    wait_all_replies();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("buffer_index_pool regression: pass");
    end else begin
      $display("buffer_index_pool regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("buffer_index_pool regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
rtl/bip_pkg.sv
rtl/bip_ram.sv
rtl/buffer_index_pool.sv
dv/testbench.sv
